// File: sv/pfr_pkg.sv
// pfr_pkg: shared types, codes and constants of the page frame replacement unit
// no dependencies
package pfr_pkg;

	localparam int MAX_FRAMES = 64;
	localparam int PAGE_BITS  = 19;
	localparam int FRAME_W    = 6;
	localparam int COUNT_W    = 7;
	localparam int TIME_W     = 32;
	localparam int NEXT_W     = 33;
	localparam int DIST_W     = 25;
	localparam int CFG_W      = 7;

	localparam logic [1:0] POL_OPT   = 2'd0;
	localparam logic [1:0] POL_LRU   = 2'd1;
	localparam logic [1:0] POL_CLOCK = 2'd2;
	localparam logic [1:0] POL_SPARE = 2'd3;

	localparam logic [1:0] CMD_STORE  = 2'd2;
	localparam logic [1:0] CMD_MODIFY = 2'd3;

	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_FRAMES = 1'b1;

	localparam logic [1:0]        POLICY_RESET = POL_LRU;
	localparam logic [COUNT_W-1:0] FRAMES_RESET = COUNT_W'(MAX_FRAMES);

	typedef struct packed {
		logic [PAGE_BITS-1:0] page;
		logic                 dirty;
		logic                 refd;
		logic [TIME_W-1:0]    used_at;
		logic [NEXT_W-1:0]    due_at;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_CLK_RD,
		ST_CLK_CHK,
		ST_DONE
	} state_t;

endpackage

// File: sv/page_frame_replacement_unit.sv
// page_frame_replacement_unit: frame table in one synchronous memory, lookup scan,
// optimal / lru / clock victim selection; depends on pfr_pkg
//
// channel   dir  handshake           payload
// in        in   in_valid/in_stall   cmd, page_number, next_distance
// out       out  out_valid/out_stall fault, frame, evicted, evicted_page, write_back
// cfg       in   cfg_we              cfg_index, cfg_data
//
// one request at a time: a lookup scan over the n frames (one memory read per frame, cut
// short by a hit), then a table update, a load of the output register and the idle state
// before the next request.
// clock policy adds a read and a check for each frame visited by the hand.
// reset empties the table at once through per-frame valid flops, policy lru, 64 frames.
// a stalled result holds; the next request is taken once the result register is loaded.
module page_frame_replacement_unit
	import pfr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           cmd,
	input  logic [PAGE_BITS-1:0] page_number,
	input  logic signed [DIST_W-1:0] next_distance,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 fault,
	output logic [FRAME_W-1:0]   frame,
	output logic                 evicted,
	output logic [PAGE_BITS-1:0] evicted_page,
	output logic                 write_back,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	entry_t mem [MAX_FRAMES];
	entry_t rd_data_s1;
	logic [FRAME_W-1:0] idx_s1;
	logic rd_vld_s1;

	state_t state_q, state_d;
	logic [1:0]         policy_q;
	logic [COUNT_W-1:0] n_q, free_q, sc_idx_q;
	logic [MAX_FRAMES-1:0] valid_q;
	logic [TIME_W-1:0]  time_q;
	logic [FRAME_W-1:0] hand_q, h_q;

	logic [PAGE_BITS-1:0] page_q;
	logic                 writes_q;
	logic [NEXT_W-1:0]    nu_q;
	logic                 hit_q;
	logic [FRAME_W-1:0]   hit_idx_q;
	logic                 hit_dirty_q;

	logic [NEXT_W-1:0]    opt_nu_q;
	logic [FRAME_W-1:0]   opt_idx_q;
	logic [PAGE_BITS-1:0] opt_page_q;
	logic                 opt_dirty_q;
	logic [TIME_W-1:0]    lru_lu_q;
	logic [FRAME_W-1:0]   lru_idx_q;
	logic [PAGE_BITS-1:0] lru_page_q;
	logic                 lru_dirty_q;

	logic                 res_fault_q, res_ev_q, res_wb_q;
	logic [FRAME_W-1:0]   res_frame_q;
	logic [PAGE_BITS-1:0] res_page_q;

	logic in_acc, hit_now, free_ok, scan_done, fin, out_free;
	logic mem_re, mem_we;
	logic [FRAME_W-1:0] mem_raddr, mem_waddr, h_next;
	entry_t mem_wdata, new_ent;
	logic                 fin_fault, fin_ev, fin_wb;
	logic [FRAME_W-1:0]   fin_frame;
	logic [PAGE_BITS-1:0] fin_page;
	logic [COUNT_W-1:0]   cfg_n;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign hit_now  = (state_q == ST_SCAN) && rd_vld_s1 && !hit_q && valid_q[idx_s1]
		&& (rd_data_s1.page == page_q);
	assign scan_done = hit_now || (sc_idx_q == n_q && !rd_vld_s1);
	assign free_ok  = (free_q != '0) && (free_q <= n_q);
	assign h_next   = (({1'b0, h_q} + COUNT_W'(1)) == n_q) ? '0 : h_q + FRAME_W'(1);
	assign cfg_n    = (cfg_data == '0) ? COUNT_W'(1) :
		(cfg_data > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES) : cfg_data;

	always_comb begin
		new_ent.page    = page_q;
		new_ent.dirty   = writes_q;
		new_ent.refd    = 1'b1;
		new_ent.used_at = time_q;
		new_ent.due_at  = nu_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!hit_q && !free_ok && policy_q == POL_CLOCK) state_d = ST_CLK_RD;
				else state_d = ST_DONE;
			end
			ST_CLK_RD: state_d = ST_CLK_CHK;
			ST_CLK_CHK: begin
				if (rd_data_s1.refd) state_d = ST_CLK_RD;
				else state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		mem_re    = 1'b0;
		mem_raddr = sc_idx_q[FRAME_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = new_ent;
		fin       = 1'b0;
		fin_fault = 1'b1;
		fin_frame = '0;
		fin_ev    = 1'b0;
		fin_page  = '0;
		fin_wb    = 1'b0;
		unique case (state_q)
			ST_SCAN: begin
				mem_re = (sc_idx_q < n_q) && !hit_q && !hit_now;
			end
			ST_DECIDE: begin
				priority if (hit_q) begin
					mem_we          = 1'b1;
					mem_waddr       = hit_idx_q;
					mem_wdata.dirty = hit_dirty_q | writes_q;
					fin             = 1'b1;
					fin_fault       = 1'b0;
					fin_frame       = hit_idx_q;
				end else if (free_ok) begin
					mem_we    = 1'b1;
					mem_waddr = free_q[FRAME_W-1:0] - FRAME_W'(1);
					fin       = 1'b1;
					fin_frame = mem_waddr;
				end else if (policy_q == POL_OPT) begin
					mem_we    = 1'b1;
					mem_waddr = opt_idx_q;
					fin       = 1'b1;
					fin_frame = opt_idx_q;
					fin_ev    = valid_q[opt_idx_q];
					fin_page  = fin_ev ? opt_page_q : '0;
					fin_wb    = fin_ev && opt_dirty_q;
				end else if (policy_q != POL_CLOCK) begin
					mem_we    = 1'b1;
					mem_waddr = lru_idx_q;
					fin       = 1'b1;
					fin_frame = lru_idx_q;
					fin_ev    = valid_q[lru_idx_q];
					fin_page  = fin_ev ? lru_page_q : '0;
					fin_wb    = fin_ev && lru_dirty_q;
				end else begin
					fin = 1'b0;
				end
			end
			ST_CLK_RD: begin
				mem_re    = 1'b1;
				mem_raddr = h_q;
			end
			ST_CLK_CHK: begin
				mem_we    = 1'b1;
				mem_waddr = h_q;
				if (rd_data_s1.refd) begin
					mem_wdata      = rd_data_s1;
					mem_wdata.refd = 1'b0;
				end else begin
					fin       = 1'b1;
					fin_frame = h_q;
					fin_ev    = valid_q[h_q];
					fin_page  = fin_ev ? rd_data_s1.page : '0;
					fin_wb    = fin_ev && rd_data_s1.dirty;
				end
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// frame table
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_data_s1 <= mem[mem_raddr];
		idx_s1 <= mem_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			policy_q  <= POLICY_RESET;
			n_q       <= FRAMES_RESET;
			free_q    <= FRAMES_RESET;
			valid_q   <= '0;
			time_q    <= '0;
			hand_q    <= '0;
			h_q       <= '0;
			rd_vld_s1 <= 1'b0;
			sc_idx_q  <= '0;
			hit_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= mem_re;
			if (cfg_we) begin
				if (cfg_index == REG_POLICY) begin
					policy_q <= cfg_data[1:0];
				end else begin
					n_q     <= cfg_n;
					free_q  <= cfg_n;
					valid_q <= '0;
					hand_q  <= '0;
				end
			end
			if (in_acc) begin
				sc_idx_q <= '0;
				hit_q    <= 1'b0;
			end
			if (mem_re && state_q == ST_SCAN) sc_idx_q <= sc_idx_q + COUNT_W'(1);
			if (hit_now) hit_q <= 1'b1;
			if (state_q == ST_DECIDE && !hit_q) begin
				if (free_ok) free_q <= free_q - COUNT_W'(1);
				else free_q <= '0;
				h_q <= ({1'b0, hand_q} >= n_q) ? '0 : hand_q;
			end
			if (state_q == ST_CLK_CHK) begin
				h_q <= h_next;
				if (!rd_data_s1.refd) hand_q <= h_next;
			end
			if (fin) begin
				valid_q[mem_waddr] <= 1'b1;
				time_q             <= time_q + TIME_W'(1);
			end
			if (state_q == ST_DONE && out_free) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	// request and scan payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			page_q   <= page_number;
			writes_q <= (cmd == CMD_STORE) || (cmd == CMD_MODIFY);
			nu_q     <= next_distance[DIST_W-1] ? '1
				: {1'b0, time_q} + NEXT_W'(next_distance[DIST_W-2:0]);
		end
		if (hit_now) begin
			hit_idx_q   <= idx_s1;
			hit_dirty_q <= rd_data_s1.dirty;
		end
		if (state_q == ST_SCAN && rd_vld_s1 && !hit_q) begin
			if (idx_s1 == '0 || rd_data_s1.due_at > opt_nu_q) begin
				opt_nu_q    <= rd_data_s1.due_at;
				opt_idx_q   <= idx_s1;
				opt_page_q  <= rd_data_s1.page;
				opt_dirty_q <= rd_data_s1.dirty;
			end
			if (idx_s1 == '0 || rd_data_s1.used_at < lru_lu_q) begin
				lru_lu_q    <= rd_data_s1.used_at;
				lru_idx_q   <= idx_s1;
				lru_page_q  <= rd_data_s1.page;
				lru_dirty_q <= rd_data_s1.dirty;
			end
		end
		if (fin) begin
			res_fault_q <= fin_fault;
			res_frame_q <= fin_frame;
			res_ev_q    <= fin_ev;
			res_page_q  <= fin_page;
			res_wb_q    <= fin_wb;
		end
		if (state_q == ST_DONE && out_free) begin
			fault        <= res_fault_q;
			frame        <= res_frame_q;
			evicted      <= res_ev_q;
			evicted_page <= res_page_q;
			write_back   <= res_wb_q;
		end
	end

`ifndef SYNTHESIS
	a_free_le_n: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= n_q) else $error("free count above frame count");
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE)) else $error("result without done");
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !fault) |-> !evicted) else $error("eviction on a hit");
	a_hand_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLK_RD) |-> ({1'b0, h_q} < n_q)) else $error("clock hand out of range");
	a_single_req: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("request taken while busy");
`endif

endmodule
